@@ hw/rtl/ssc_pkg.sv @@
package ssc_pkg;

    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 13;
    localparam int CNT_W   = 11;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // results one point can cause: closed segment, flushed segment, scan end
    localparam int PUSH_MAX    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RANGE  = 3'd0,
        CFG_MAX_RANGE  = 3'd1,
        CFG_RANGE_GAP  = 3'd2,
        CFG_ANGLE_GAP  = 3'd3,
        CFG_MIN_POINTS = 3'd4,
        CFG_MAX_POINTS = 3'd5
    } ssc_cfg_idx_t;

    localparam logic [RANGE_W-1:0] RST_MIN_RANGE  = 16'd190;
    localparam logic [RANGE_W-1:0] RST_MAX_RANGE  = 16'd2000;
    localparam logic [RANGE_W-1:0] RST_RANGE_GAP  = 16'd400;
    localparam logic [ANGLE_W-1:0] RST_ANGLE_GAP  = 13'd400;
    localparam logic [CNT_W-1:0]   RST_MIN_POINTS = 11'd18;
    localparam logic [CNT_W-1:0]   RST_MAX_POINTS = 11'd200;

    typedef struct packed {
        logic                      has_segment;
        logic [RANGE_W-1:0]        mid_range_mm;
        logic signed [ANGLE_W-1:0] mid_angle_mrad;
        logic [CNT_W-1:0]          point_count;
        logic                      scan_end;
        logic [CNT_W-1:0]          segments_in_scan;
    } ssc_result_t;

    typedef struct packed {
        logic [1:0]                  num;
        ssc_result_t [PUSH_MAX-1:0]  data;
    } ssc_push_t;

endpackage

@@ hw/rtl/ssc_seg_core.sv @@
module ssc_seg_core import ssc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_addr,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [RANGE_W-1:0]        s_range_mm,
    input  logic signed [ANGLE_W-1:0] s_angle_mrad,
    input  logic                      s_scan_last,
    input  logic                      room,
    output ssc_push_t                 push
);

    // configuration
    logic [RANGE_W-1:0] min_range_reg, max_range_reg, range_gap_reg;
    logic [ANGLE_W-1:0] angle_gap_reg;
    logic [CNT_W-1:0]   min_points_reg, max_points_reg;

    // input register
    logic                      in_valid_reg;
    logic [RANGE_W-1:0]        in_range_reg;
    logic signed [ANGLE_W-1:0] in_angle_reg;
    logic                      in_last_reg;

    // scan state
    logic                      in_segment_reg, in_segment_next;
    logic [CNT_W-1:0]          segment_points_reg, segment_points_next;
    logic [CNT_W-1:0]          reported_count_reg, reported_count_next;
    logic [RANGE_W-1:0]        previous_range_reg, previous_range_next;
    logic signed [ANGLE_W-1:0] previous_angle_reg, previous_angle_next;
    logic [RANGE_W-1:0]        first_range_reg, first_range_next;
    logic signed [ANGLE_W-1:0] first_angle_reg, first_angle_next;
    logic [RANGE_W-1:0]        last_range_reg, last_range_next;
    logic signed [ANGLE_W-1:0] last_angle_reg, last_angle_next;

    logic                      advance;
    logic                      in_band, cont;
    logic [RANGE_W-1:0]        dr;
    logic signed [ANGLE_W:0]   sa;
    logic [ANGLE_W:0]          da;
    logic                      rep1, rep2;
    logic [CNT_W-1:0]          rc1, rc2;
    logic                      seg1;
    logic [CNT_W-1:0]          pts1;
    logic [RANGE_W-1:0]        f_range1, l_range1;
    logic signed [ANGLE_W-1:0] f_angle1, l_angle1;
    logic [RANGE_W:0]          rsum0, rsum1;
    logic signed [ANGLE_W:0]   asum0, asum1;
    ssc_result_t               res1, res2, res_end;
    logic [1:0]                k;

    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_range_reg  <= RST_MIN_RANGE;
            max_range_reg  <= RST_MAX_RANGE;
            range_gap_reg  <= RST_RANGE_GAP;
            angle_gap_reg  <= RST_ANGLE_GAP;
            min_points_reg <= RST_MIN_POINTS;
            max_points_reg <= RST_MAX_POINTS;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MIN_RANGE:  min_range_reg  <= cfg_wdata;
                CFG_MAX_RANGE:  max_range_reg  <= cfg_wdata;
                CFG_RANGE_GAP:  range_gap_reg  <= cfg_wdata;
                CFG_ANGLE_GAP:  angle_gap_reg  <= cfg_wdata[ANGLE_W-1:0];
                CFG_MIN_POINTS: min_points_reg <= cfg_wdata[CNT_W-1:0];
                CFG_MAX_POINTS: max_points_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_range_reg <= s_range_mm;
            in_angle_reg <= s_angle_mrad;
            in_last_reg  <= s_scan_last;
        end
    end

    always_comb begin
        in_band = (in_range_reg > min_range_reg) && (in_range_reg < max_range_reg);
        dr = (in_range_reg >= previous_range_reg) ? in_range_reg - previous_range_reg
                                                  : previous_range_reg - in_range_reg;
        sa = {in_angle_reg[ANGLE_W-1], in_angle_reg}
           - {previous_angle_reg[ANGLE_W-1], previous_angle_reg};
        da = sa[ANGLE_W] ? (ANGLE_W+1)'(-sa) : (ANGLE_W+1)'(sa);
        cont = in_segment_reg && (dr < range_gap_reg) && (da < {1'b0, angle_gap_reg});

        // segment closed by a jump
        rep1 = in_band && !cont && in_segment_reg
            && (segment_points_reg > min_points_reg)
            && (segment_points_reg < max_points_reg);
        rc1 = (rep1 && reported_count_reg != CNT_MAX) ? reported_count_reg + 1'b1
                                                      : reported_count_reg;

        seg1     = in_segment_reg;
        pts1     = segment_points_reg;
        f_range1 = first_range_reg;
        f_angle1 = first_angle_reg;
        l_range1 = last_range_reg;
        l_angle1 = last_angle_reg;
        if (in_band) begin
            seg1 = 1'b1;
            if (cont) begin
                pts1 = (segment_points_reg != CNT_MAX) ? segment_points_reg + 1'b1
                                                       : segment_points_reg;
            end else begin
                pts1     = CNT_W'(1);
                f_range1 = in_range_reg;
                f_angle1 = in_angle_reg;
            end
            l_range1 = in_range_reg;
            l_angle1 = in_angle_reg;
        end

        // flush of the open segment at end of scan
        rep2 = in_last_reg && seg1 && (pts1 > min_points_reg) && (pts1 < max_points_reg);
        rc2  = (rep2 && rc1 != CNT_MAX) ? rc1 + 1'b1 : rc1;

        rsum0 = {1'b0, first_range_reg} + {1'b0, last_range_reg};
        asum0 = {first_angle_reg[ANGLE_W-1], first_angle_reg}
              + {last_angle_reg[ANGLE_W-1], last_angle_reg};
        rsum1 = {1'b0, f_range1} + {1'b0, l_range1};
        asum1 = {f_angle1[ANGLE_W-1], f_angle1} + {l_angle1[ANGLE_W-1], l_angle1};

        res1.has_segment      = 1'b1;
        res1.mid_range_mm     = rsum0[RANGE_W:1];
        res1.mid_angle_mrad   = asum0[ANGLE_W:1];
        res1.point_count      = segment_points_reg;
        res1.scan_end         = 1'b0;
        res1.segments_in_scan = rc1;

        res2.has_segment      = 1'b1;
        res2.mid_range_mm     = rsum1[RANGE_W:1];
        res2.mid_angle_mrad   = asum1[ANGLE_W:1];
        res2.point_count      = pts1;
        res2.scan_end         = 1'b0;
        res2.segments_in_scan = rc2;

        res_end                  = '0;
        res_end.scan_end         = 1'b1;
        res_end.segments_in_scan = rc2;

        // pack the results of this beat into consecutive slots
        push.data = '0;
        k = 2'd0;
        if (rep1) begin
            push.data[k] = res1;
            k = k + 2'd1;
        end
        if (rep2) begin
            push.data[k] = res2;
            k = k + 2'd1;
        end
        if (in_last_reg) begin
            push.data[k] = res_end;
            k = k + 2'd1;
        end
        push.num = advance ? k : 2'd0;

        previous_range_next = in_band ? in_range_reg : previous_range_reg;
        previous_angle_next = in_band ? in_angle_reg : previous_angle_reg;
        first_range_next    = f_range1;
        first_angle_next    = f_angle1;
        last_range_next     = l_range1;
        last_angle_next     = l_angle1;
        if (in_last_reg) begin
            in_segment_next     = 1'b0;
            segment_points_next = '0;
            reported_count_next = '0;
        end else begin
            in_segment_next     = seg1;
            segment_points_next = pts1;
            reported_count_next = rc1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_segment_reg     <= 1'b0;
            segment_points_reg <= '0;
            reported_count_reg <= '0;
        end else if (advance) begin
            in_segment_reg     <= in_segment_next;
            segment_points_reg <= segment_points_next;
            reported_count_reg <= reported_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            previous_range_reg <= previous_range_next;
            previous_angle_reg <= previous_angle_next;
            first_range_reg    <= first_range_next;
            first_angle_reg    <= first_angle_next;
            last_range_reg     <= last_range_next;
            last_angle_reg     <= last_angle_next;
        end
    end

    a_open_has_points: assert property (@(posedge aclk) disable iff (!aresetn)
        in_segment_reg == (segment_points_reg != '0))
        else $error("open segment flag and point count disagree");

    a_scan_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> !in_segment_reg && reported_count_reg == '0)
        else $error("scan state not cleared after last point");

    a_end_result_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |-> push.num != 2'd0)
        else $error("last point produced no scan end result");

endmodule

@@ hw/rtl/ssc_out_queue.sv @@
module ssc_out_queue import ssc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  ssc_push_t   push,
    output logic        room,
    output logic        m_valid,
    input  logic        m_ready,
    output ssc_result_t m_data
);

    localparam logic [QCNT_W-1:0] ROOM_LEVEL = QCNT_W'(QUEUE_DEPTH - PUSH_MAX);

    ssc_result_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               pop;

    // room for a whole beat's worth of results
    assign room    = count_reg <= ROOM_LEVEL;
    assign m_valid = count_reg != '0;
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.num) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PUSH_MAX; i++) begin
            if (i < int'(push.num)) begin
                mem_reg[wr_ptr_reg + QPTR_W'(i)] <= push.data[i];
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.num != 2'd0 |-> count_reg <= ROOM_LEVEL)
        else $error("results pushed without room");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count out of range");

endmodule

@@ hw/rtl/scan_segment_clusterer.sv @@
// scan segment clusterer
// s_ channel: one scan point per beat (range, bearing, last-of-scan flag).
// m_ channel: one result per beat, either a reported segment (midpoints and
// point count) or, after the last point of a scan, a scan end result with
// the number of segments reported in that scan.
// configuration: cfg_we writes cfg_wdata into register cfg_addr at the
// clock edge; write only while the block is idle.
// flow: an accepted point waits in the input register; its results enter
// the result queue once it has room and are shown on m_ from there. the
// segment core is combinational. one point per cycle is sustained while
// each point gives at most one result and m_ready stays high. a point
// giving two or three results holds the core until the four-entry result
// queue has room for three; the m_ side then sets the rate, one result per cycle.
// receiver stall: results wait in the queue, the core stops once fewer than
// three entries are free, then s_ready drops after the input register fills.
// reset (aresetn low, synchronous): registers return to their defaults, the
// scan state clears and the queue empties.
module scan_segment_clusterer import ssc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_addr,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [RANGE_W-1:0]        s_range_mm,
    input  logic signed [ANGLE_W-1:0] s_angle_mrad,
    input  logic                      s_scan_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_has_segment,
    output logic [RANGE_W-1:0]        m_mid_range_mm,
    output logic signed [ANGLE_W-1:0] m_mid_angle_mrad,
    output logic [CNT_W-1:0]          m_point_count,
    output logic                      m_scan_end,
    output logic [CNT_W-1:0]          m_segments_in_scan
);

    ssc_push_t   push;
    logic        room;
    ssc_result_t m_data;

    ssc_seg_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_range_mm   (s_range_mm),
        .s_angle_mrad (s_angle_mrad),
        .s_scan_last  (s_scan_last),
        .room         (room),
        .push         (push)
    );

    ssc_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign m_has_segment      = m_data.has_segment;
    assign m_mid_range_mm     = m_data.mid_range_mm;
    assign m_mid_angle_mrad   = m_data.mid_angle_mrad;
    assign m_point_count      = m_data.point_count;
    assign m_scan_end         = m_data.scan_end;
    assign m_segments_in_scan = m_data.segments_in_scan;

endmodule
